[rtl/dtti_pkg.sv]
// Package for the checked decimal text to integer converter.
// Holds character codes, type limits, register indexes and reset values.
// Used by decimal_text_to_integer_checked and the testbench; depends on nothing.
package dtti_pkg;

  localparam int CharW  = 8;
  localparam int ValueW = 64;
  localparam int ProdW  = ValueW + 4;

  localparam logic [CharW-1:0] CH_MINUS = 8'd45;
  localparam logic [CharW-1:0] CH_ZERO  = 8'd48;
  localparam logic [CharW-1:0] CH_NINE  = 8'd57;

  localparam logic [ValueW-1:0] MAX32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [ValueW-1:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_WIDE_MODE = 1'b1;

  localparam logic [CharW-1:0] SEPARATOR_RESET = 8'd44;
  localparam logic             WIDE_MODE_RESET = 1'b1;

endpackage

[rtl/decimal_text_to_integer_checked.sv]
// Checked decimal text to signed integer converter, top level.
// A result is on the output in the cycle after the transfer of the field's last item.
// Throughput: one item per cycle unless a waiting result stalls the input; the multiply-by-ten
// add and limit compare into the magnitude register set the cycle.
// Reset (synchronous, rst_n low) clears the field state and sets the separator to ','
// and the mode to 64-bit. Depends on dtti_pkg.
module decimal_text_to_integer_checked (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dtti_pkg::CharW-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dtti_pkg::CharW-1:0]          in_char_code,
  input  logic                                in_has_char,
  input  logic                                in_field_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dtti_pkg::ValueW-1:0]  out_int_value,
  output logic                                out_out_of_range
);

  logic [dtti_pkg::CharW-1:0]  separator_r;
  logic                        wide_mode_r;

  logic [dtti_pkg::ValueW-1:0] magnitude_r, magnitude_nxt;
  logic                        negative_r, negative_nxt;
  logic                        at_start_r, at_start_nxt;
  logic                        stopped_r, stopped_nxt;
  logic                        overflowed_r, overflowed_nxt;

  logic                        out_valid_r;
  logic [dtti_pkg::ValueW-1:0] out_value_r, out_value_nxt;
  logic                        out_range_r, out_range_nxt;

  logic                        in_xfer, out_xfer;
  logic [3:0]                  digit;
  logic                        is_digit;
  logic [dtti_pkg::ValueW-1:0] top_limit, digit_limit, end_limit;
  logic [dtti_pkg::ProdW-1:0]  mag_ext, product;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;

  assign digit      = in_char_code[3:0] - dtti_pkg::CH_ZERO[3:0];
  assign is_digit   = (in_char_code >= dtti_pkg::CH_ZERO) && (in_char_code <= dtti_pkg::CH_NINE);
  assign top_limit  = wide_mode_r ? dtti_pkg::MAX64 : dtti_pkg::MAX32;
  assign digit_limit = top_limit + {{(dtti_pkg::ValueW-1){1'b0}}, negative_r};
  assign mag_ext    = {4'b0000, magnitude_r};
  assign product    = (mag_ext << 3) + (mag_ext << 1) + {{(dtti_pkg::ProdW-4){1'b0}}, digit};

  always_comb begin
    magnitude_nxt  = magnitude_r;
    negative_nxt   = negative_r;
    at_start_nxt   = at_start_r;
    stopped_nxt    = stopped_r;
    overflowed_nxt = overflowed_r;
    if (in_has_char) begin
      at_start_nxt = 1'b0;
      if (!stopped_r && !overflowed_r) begin
        if (at_start_r && (in_char_code == dtti_pkg::CH_MINUS)) begin
          negative_nxt = 1'b1;
        end else if (in_char_code == separator_r) begin
          magnitude_nxt = magnitude_r;
        end else if (is_digit) begin
          if (product > {4'b0000, digit_limit}) begin
            overflowed_nxt = 1'b1;
          end else begin
            magnitude_nxt = product[dtti_pkg::ValueW-1:0];
          end
        end else begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  assign end_limit = top_limit + {{(dtti_pkg::ValueW-1){1'b0}}, negative_nxt};

  always_comb begin
    out_range_nxt = overflowed_nxt || (magnitude_nxt > end_limit);
    if (out_range_nxt) begin
      out_value_nxt = '0;
    end else if (negative_nxt) begin
      out_value_nxt = '0 - magnitude_nxt;
    end else begin
      out_value_nxt = magnitude_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r <= dtti_pkg::SEPARATOR_RESET;
      wide_mode_r <= dtti_pkg::WIDE_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtti_pkg::REG_SEPARATOR: separator_r <= cfg_wdata;
        dtti_pkg::REG_WIDE_MODE: wide_mode_r <= cfg_wdata[0];
        default: separator_r <= separator_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magnitude_r  <= '0;
      negative_r   <= 1'b0;
      at_start_r   <= 1'b1;
      stopped_r    <= 1'b0;
      overflowed_r <= 1'b0;
    end else if (in_xfer) begin
      if (in_field_end) begin
        magnitude_r  <= '0;
        negative_r   <= 1'b0;
        at_start_r   <= 1'b1;
        stopped_r    <= 1'b0;
        overflowed_r <= 1'b0;
      end else begin
        magnitude_r  <= magnitude_nxt;
        negative_r   <= negative_nxt;
        at_start_r   <= at_start_nxt;
        stopped_r    <= stopped_nxt;
        overflowed_r <= overflowed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_field_end) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_field_end) begin
      out_value_r <= out_value_nxt;
      out_range_r <= out_range_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_int_value    = out_value_r;
  assign out_out_of_range = out_range_r;

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_range_r |-> out_value_r == '0)
    else $error("Out-of-range result carries a nonzero value.");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_field_end |=> out_valid_r && at_start_r && magnitude_r == '0)
    else $error("Field end did not produce a result and clear the field state.");

  a_narrow_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !wide_mode_r |->
      (out_value_r[63:31] == '0) || (out_value_r[63:31] == '1))
    else $error("32-bit result is not sign-extended.");

  a_magnitude_bound: assert property (@(posedge clk) disable iff (!rst_n)
    magnitude_r <= (dtti_pkg::MAX64 + 64'd1))
    else $error("Magnitude exceeds the largest legal value.");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for decimal_text_to_integer_checked: sends the characters of text fields
// and checks every converted integer against a predictor of the converter.
// Depends on dtti_pkg and the converter RTL.
module testbench;

  typedef enum int {CLOSE_OPEN, CLOSE_ON_CHAR, CLOSE_SEPARATE} close_t;

  class conversion_scoreboard;
    logic [dtti_pkg::CharW-1:0]  separator;
    bit                          wide;
    logic [dtti_pkg::ValueW-1:0] magnitude;
    bit                          negative;
    bit                          at_start;
    bit                          stopped;
    bit                          overflowed;
    logic [dtti_pkg::ValueW-1:0] value_q[$];
    bit                          range_q[$];
    int                          mismatches;
    int                          checked;
    int                          overflow_seen;
    int                          negative_seen;

    function new();
      separator = dtti_pkg::SEPARATOR_RESET;
      wide = dtti_pkg::WIDE_MODE_RESET;
      mismatches = 0;
      checked = 0;
      overflow_seen = 0;
      negative_seen = 0;
      clear_field();
    endfunction

    function void clear_field();
      magnitude = '0;
      negative = 1'b0;
      at_start = 1'b1;
      stopped = 1'b0;
      overflowed = 1'b0;
    endfunction

    function void queue_result(logic [dtti_pkg::ValueW-1:0] v, bit r);
      value_q = {value_q, v};
      range_q = {range_q, r};
    endfunction

    function logic [dtti_pkg::ValueW-1:0] field_limit();
      return (wide ? dtti_pkg::MAX64 : dtti_pkg::MAX32) + (negative ? 64'd1 : 64'd0);
    endfunction

    function void note_input(logic [dtti_pkg::CharW-1:0] c, bit has, bit fend);
      bit                          first;
      logic [dtti_pkg::ValueW-1:0] digit;
      if (has) begin
        first = at_start;
        at_start = 1'b0;
        if (!stopped && !overflowed) begin
          if (first && c == dtti_pkg::CH_MINUS) begin
            negative = 1'b1;
          end else if (c != separator) begin
            if (c >= dtti_pkg::CH_ZERO && c <= dtti_pkg::CH_NINE) begin
              digit = {{(dtti_pkg::ValueW-dtti_pkg::CharW){1'b0}}, c - dtti_pkg::CH_ZERO};
              if (magnitude > (field_limit() - digit) / 64'd10) begin
                overflowed = 1'b1;
              end else begin
                magnitude = magnitude * 64'd10 + digit;
              end
            end else begin
              stopped = 1'b1;
            end
          end
        end
      end
      if (fend) begin
        if (!overflowed && magnitude > field_limit()) overflowed = 1'b1;
        if (overflowed) queue_result(64'd0, overflowed);
        else if (negative) queue_result(64'd0 - magnitude, overflowed);
        else queue_result(magnitude, overflowed);
        clear_field();
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task check_result(logic [dtti_pkg::ValueW-1:0] v, logic oor);
      logic [dtti_pkg::ValueW-1:0] want_v;
      bit                          want_r;
      if (value_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no field pending", $signed(v)));
      end else begin
        want_v = value_q.pop_front();
        want_r = range_q.pop_front();
        checked++;
        if (want_r) overflow_seen++;
        else if (want_v[dtti_pkg::ValueW-1]) negative_seen++;
        if (v !== want_v)
          report_mismatch($sformatf("int_value %0d, expected %0d", $signed(v),
                                    $signed(want_v)));
        if (oor !== want_r)
          report_mismatch($sformatf("out_of_range %b, expected %b", oor, want_r));
      end
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic                               cfg_index;
  logic [dtti_pkg::CharW-1:0]         cfg_wdata;
  logic                               in_valid;
  logic                               in_ready;
  logic [dtti_pkg::CharW-1:0]         in_char_code;
  logic                               in_has_char;
  logic                               in_field_end;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [dtti_pkg::ValueW-1:0] out_int_value;
  logic                               out_out_of_range;

  conversion_scoreboard       sb;
  bit                         steady;
  int                         items_sent;
  logic [dtti_pkg::CharW-1:0] text[$];

  decimal_text_to_integer_checked i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_char_code, .in_has_char, .in_field_end,
    .out_valid, .out_ready, .out_int_value, .out_out_of_range
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready)
        sb.check_result(out_int_value, out_out_of_range);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && sb.checked >= 25) begin
        hold_left = 60;
        hold_done = 1'b1;
      end
      if (hold_left > 0) out_ready <= 1'b0;
      else if (steady) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 29);
    end
  end

  task automatic add_char(input logic [dtti_pkg::CharW-1:0] c);
    text = {text, c};
  endtask

  task automatic send_item(input logic [dtti_pkg::CharW-1:0] c, input logic has,
                           input logic fend);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_has_char <= has;
    in_field_end <= fend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(c, has, fend);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.value_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [dtti_pkg::CharW-1:0] sep, input logic wide);
    cfg_we <= 1'b1;
    cfg_index <= dtti_pkg::REG_SEPARATOR;
    cfg_wdata <= sep;
    @(posedge clk);
    sb.separator = sep;
    cfg_index <= dtti_pkg::REG_WIDE_MODE;
    cfg_wdata <= {{(dtti_pkg::CharW-1){1'b0}}, wide};
    @(posedge clk);
    sb.wide = wide;
    cfg_we <= 1'b0;
  endtask

  task automatic send_text(input close_t how);
    int n;
    n = text.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, how == CLOSE_ON_CHAR && i == n - 1);
      items_sent++;
    end
    if (how == CLOSE_SEPARATE || (how == CLOSE_ON_CHAR && n == 0)) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  function automatic logic [dtti_pkg::CharW-1:0] digit_char();
    return dtti_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic make_number(input int max_digits);
    int n;
    n = $urandom_range(max_digits, 1);
    if ($urandom_range(99) < 40) add_char(dtti_pkg::CH_MINUS);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < 10) add_char(sb.separator);
      add_char(digit_char());
    end
  endtask

  task automatic make_limit();
    string s;
    case ($urandom_range(4))
      0: s = "2147483647";
      1: s = "2147483648";
      2: s = "9223372036854775807";
      3: s = "9223372036854775808";
      default: s = "18446744073709551616";
    endcase
    if ($urandom_range(1)) add_char(dtti_pkg::CH_MINUS);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    if ($urandom_range(3) == 0) text[text.size()-1] = digit_char();
  endtask

  task automatic random_field();
    int kind;
    text.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      make_number(($urandom_range(99) < 60) ? 10 : 20);
    end else if (kind < 65) begin
      make_limit();
    end else if (kind < 80) begin
      make_number(8);
      repeat ($urandom_range(4, 1)) add_char(8'($urandom));
    end else if (kind < 93) begin
      repeat ($urandom_range(6)) add_char(8'($urandom));
    end else if (kind < 97) begin
      add_char(dtti_pkg::CH_MINUS);
    end
    send_text($urandom_range(1) ? CLOSE_ON_CHAR : CLOSE_SEPARATE);
  endtask

  task automatic random_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) random_field();
    if ($urandom_range(1)) begin
      text.delete();
      make_number(12);
      send_text(CLOSE_OPEN);
    end
    settle();
  endtask

  initial begin : stimulus
    sb = new();
    steady = 1'b0;
    items_sent = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= dtti_pkg::REG_SEPARATOR;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_char_code <= '0;
    in_has_char <= 1'b0;
    in_field_end <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An empty field, a lone minus, a minus after the start and a stop on byte zero.
    send_item(8'd255, 1'b0, 1'b1);
    send_item(dtti_pkg::CH_MINUS, 1'b1, 1'b1);
    send_item(dtti_pkg::CH_MINUS, 1'b1, 1'b0);
    send_item("5", 1'b1, 1'b0);
    send_item(dtti_pkg::CH_MINUS, 1'b1, 1'b0);
    send_item("7", 1'b1, 1'b0);
    send_item(8'd0, 1'b0, 1'b1);
    send_item("1", 1'b1, 1'b0);
    send_item(dtti_pkg::SEPARATOR_RESET, 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b0);
    send_item(8'd0, 1'b1, 1'b0);
    send_item(8'd255, 1'b1, 1'b1);
    send_item(8'd255, 1'b0, 1'b0);
    settle();

    // A digit as the separator is always skipped.
    set_config(dtti_pkg::CH_ZERO, 1'b0);
    send_item("1", 1'b1, 1'b0);
    send_item("0", 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b1);
    settle();

    // The magnitude fits the 64-bit limit but not the 32-bit one set before the end.
    set_config(dtti_pkg::SEPARATOR_RESET, 1'b1);
    repeat (10) send_item("8", 1'b1, 1'b0);
    settle();
    set_config(dtti_pkg::SEPARATOR_RESET, 1'b0);
    send_item(8'd255, 1'b0, 1'b1);
    settle();

    set_config(8'd0, 1'b0);
    random_phase(180);
    set_config(8'd255, 1'b1);
    random_phase(180);
    set_config(dtti_pkg::CH_NINE, 1'b0);
    random_phase(180);
    set_config(dtti_pkg::CH_MINUS, 1'b1);
    random_phase(180);
    steady = 1'b1;
    set_config(dtti_pkg::SEPARATOR_RESET, 1'b0);
    random_phase(220);
    steady = 1'b0;
    set_config(8'($urandom), 1'b1);
    random_phase(180);
    set_config(8'($urandom), 1'b0);
    random_phase(180);

    repeat (10) @(posedge clk);
    $display("Converted %0d fields (%0d out of range, %0d negative) from %0d items",
             sb.checked, sb.overflow_seen, sb.negative_seen, items_sent);
    $display("over ten register settings, with one long stall of the result side.");
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[decimal_text_to_integer_checked.f]
rtl/dtti_pkg.sv
rtl/decimal_text_to_integer_checked.sv
test/testbench.sv
